// ===== rtl/core/binary_min_heap_defines.svh =====
// Assertion helpers for the heap controller.
`ifndef BINARY_MIN_HEAP_DEFINES_SVH
`define BINARY_MIN_HEAP_DEFINES_SVH

// Concurrent check on an explicit clock and active-low reset.
`define BMH_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on the default clock and reset of the heap modules.
`define BMH_ASSERT(lbl, prop, msg) `BMH_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/bmh_pkg.sv =====
`timescale 1ns / 1ps

package bmh_pkg;

  localparam int KEY_W    = 32;
  localparam int CAPACITY = 1024;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = CNT_W;
  localparam int NUM_LVL  = $clog2(CAPACITY + 1);
  localparam int LVL_W    = (NUM_LVL > 1) ? $clog2(NUM_LVL) : 1;
  localparam int PADDR_W  = 3;

  localparam logic OP_INSERT       = 1'b0;
  localparam logic OP_EXTRACT      = 1'b1;
  localparam logic REG_SIGNED_KEYS = 1'b0;

  // Request from the sequencer to the row of level cells.
  typedef struct packed {
    logic             we;
    logic [LVL_W-1:0] wlvl;
    logic [IDX_W-1:0] woff;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [LVL_W-1:0] rlvl;
    logic [IDX_W-1:0] roff;
    logic             reb;
  } bmh_cmd_t;

  // Port controls from one cell to its level memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic             rea;
    logic [IDX_W-1:0] raddra;
    logic             reb;
    logic [IDX_W-1:0] raddrb;
  } bmh_req_t;

  function automatic logic key_less(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b,
                                    logic sgn);
    logic [KEY_W-1:0] flip;
    flip = '0;
    flip[KEY_W-1] = sgn;
    return (a ^ flip) < (b ^ flip);
  endfunction

  // Level of a one-based node number: position of its leading one.
  function automatic logic [LVL_W-1:0] node_lvl(logic [IDX_W-1:0] k);
    logic [LVL_W-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (k[i]) begin
        lvl = LVL_W'(i);
      end
    end
    return lvl;
  endfunction

  // Offset of a one-based node number inside its level.
  function automatic logic [IDX_W-1:0] node_off(logic [IDX_W-1:0] k);
    return k & ~(IDX_W'(1) << node_lvl(k));
  endfunction

  function automatic int lvl_depth(int l);
    int full;
    int rest;
    full = 1 << l;
    rest = CAPACITY + 1 - full;
    return (rest < full) ? rest : full;
  endfunction

endpackage

// ===== rtl/core/bmh_ram.sv =====
`timescale 1ns / 1ps

module bmh_ram #(
  parameter int DEPTH = 2,
  parameter int AW    = 1,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          rea_i,
  input  logic [AW-1:0] raddra_i,
  output logic [DW-1:0] rdataa_o,
  input  logic          reb_i,
  input  logic [AW-1:0] raddrb_i,
  output logic [DW-1:0] rdatab_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdataa_q;
  logic [DW-1:0] rdatab_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rea_i) begin
      rdataa_q <= mem_q[raddra_i];
    end
    if (reb_i) begin
      rdatab_q <= mem_q[raddrb_i];
    end
  end

  assign rdataa_o = rdataa_q;
  assign rdatab_o = rdatab_q;

endmodule

// ===== rtl/core/bmh_cell.sv =====
`timescale 1ns / 1ps

module bmh_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [bmh_pkg::LVL_W-1:0]       lvl_i,
  input  bmh_pkg::bmh_cmd_t               cmd_i,
  output bmh_pkg::bmh_req_t               req_o,
  input  logic [bmh_pkg::KEY_W-1:0]       rdataa_i,
  input  logic [bmh_pkg::KEY_W-1:0]       rdatab_i,
  input  logic [bmh_pkg::KEY_W-1:0]       chain_a_i,
  input  logic [bmh_pkg::KEY_W-1:0]       chain_b_i,
  output logic [bmh_pkg::KEY_W-1:0]       chain_a_o,
  output logic [bmh_pkg::KEY_W-1:0]       chain_b_o
);

  logic rd_hit;
  logic hit_q;

  assign rd_hit = cmd_i.re && (cmd_i.rlvl == lvl_i);

  always_comb begin
    req_o.we     = cmd_i.we && (cmd_i.wlvl == lvl_i);
    req_o.waddr  = cmd_i.woff;
    req_o.wdata  = cmd_i.wdata;
    req_o.rea    = rd_hit;
    req_o.raddra = cmd_i.roff;
    req_o.reb    = rd_hit && cmd_i.reb;
    // right child sits next to the left one
    req_o.raddrb = {cmd_i.roff[bmh_pkg::IDX_W-1:1], 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= rd_hit;
    end
  end

  // pass read data up the row toward the sequencer
  assign chain_a_o = hit_q ? rdataa_i : chain_a_i;
  assign chain_b_o = hit_q ? rdatab_i : chain_b_i;

endmodule

// ===== rtl/core/bmh_ctl.sv =====
`timescale 1ns / 1ps
`include "binary_min_heap_defines.svh"

module bmh_ctl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [bmh_pkg::KEY_W-1:0]   key_i,
  input  logic                        signed_keys_i,
  output bmh_pkg::bmh_cmd_t           cmd_o,
  input  logic [bmh_pkg::KEY_W-1:0]   rda_i,
  input  logic [bmh_pkg::KEY_W-1:0]   rdb_i,
  output logic                        done_o,
  output logic                        ok_o,
  output logic [bmh_pkg::KEY_W-1:0]   out_key_o,
  output logic [bmh_pkg::CNT_W-1:0]   count_o,
  output logic                        has_min_o,
  output logic [bmh_pkg::KEY_W-1:0]   min_key_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_LAST,
    ST_DN_CHK,
    ST_DN_CMP,
    ST_RESP
  } state_e;

  state_e                          state_q;
  logic [bmh_pkg::IDX_W-1:0]       pos_q;
  logic [bmh_pkg::KEY_W-1:0]       cur_q;
  logic [bmh_pkg::CNT_W-1:0]       count_q;
  logic [bmh_pkg::KEY_W-1:0]       min_q;
  logic                            rc_ok_q;
  logic                            done_q;
  logic                            ok_q;
  logic [bmh_pkg::KEY_W-1:0]       out_key_q;

  logic                            accept;
  logic [bmh_pkg::LVL_W-1:0]       lvl_pos;
  logic [bmh_pkg::IDX_W-1:0]       off_pos;
  logic [bmh_pkg::IDX_W-1:0]       par;
  logic [bmh_pkg::IDX_W:0]         lc_node;
  logic [bmh_pkg::IDX_W:0]         rc_node;
  logic                            lc_in;
  logic                            rc_in;
  logic                            up_swap;
  logic                            take_l;
  logic [bmh_pkg::KEY_W-1:0]       best_l;
  logic                            take_r;
  logic [bmh_pkg::KEY_W-1:0]       best_key;

  assign accept  = start && (state_q == ST_IDLE);
  assign busy    = (state_q != ST_IDLE);

  assign lvl_pos = bmh_pkg::node_lvl(pos_q);
  assign off_pos = bmh_pkg::node_off(pos_q);
  assign par     = {1'b0, pos_q[bmh_pkg::IDX_W-1:1]};
  assign lc_node = {pos_q, 1'b0};
  assign rc_node = {pos_q, 1'b1};
  assign lc_in   = lc_node <= {1'b0, count_q};
  assign rc_in   = rc_node <= {1'b0, count_q};

  assign up_swap  = bmh_pkg::key_less(cur_q, rda_i, signed_keys_i);
  assign take_l   = bmh_pkg::key_less(rda_i, cur_q, signed_keys_i);
  assign best_l   = take_l ? rda_i : cur_q;
  assign take_r   = rc_ok_q && bmh_pkg::key_less(rdb_i, best_l, signed_keys_i);
  assign best_key = take_r ? rdb_i : best_l;

  always_comb begin
    cmd_o = '0;
    unique case (state_q) inside
      ST_IDLE: begin
        // fetch the last entry, it moves to the root
        if (accept && (op_i == bmh_pkg::OP_EXTRACT) &&
            (count_q > bmh_pkg::CNT_W'(1))) begin
          cmd_o.re   = 1'b1;
          cmd_o.rlvl = bmh_pkg::node_lvl(count_q);
          cmd_o.roff = bmh_pkg::node_off(count_q);
        end
      end
      ST_UP_CHK: begin
        if (pos_q == bmh_pkg::IDX_W'(1)) begin
          cmd_o.we    = 1'b1;
          cmd_o.wlvl  = lvl_pos;
          cmd_o.woff  = off_pos;
          cmd_o.wdata = cur_q;
        end else begin
          cmd_o.re   = 1'b1;
          cmd_o.rlvl = bmh_pkg::node_lvl(par);
          cmd_o.roff = bmh_pkg::node_off(par);
        end
      end
      ST_UP_CMP: begin
        cmd_o.we    = 1'b1;
        cmd_o.wlvl  = lvl_pos;
        cmd_o.woff  = off_pos;
        cmd_o.wdata = up_swap ? rda_i : cur_q;
      end
      ST_DN_CHK: begin
        if (!lc_in) begin
          cmd_o.we    = 1'b1;
          cmd_o.wlvl  = lvl_pos;
          cmd_o.woff  = off_pos;
          cmd_o.wdata = cur_q;
        end else begin
          cmd_o.re   = 1'b1;
          cmd_o.rlvl = lvl_pos + bmh_pkg::LVL_W'(1);
          cmd_o.roff = {off_pos[bmh_pkg::IDX_W-2:0], 1'b0};
          cmd_o.reb  = rc_in;
        end
      end
      ST_DN_CMP: begin
        cmd_o.we    = 1'b1;
        cmd_o.wlvl  = lvl_pos;
        cmd_o.woff  = off_pos;
        cmd_o.wdata = best_key;
      end
      ST_DN_LAST, ST_RESP: begin
        cmd_o = '0;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      cur_q     <= '0;
      count_q   <= '0;
      min_q     <= '0;
      rc_ok_q   <= 1'b0;
      done_q    <= 1'b0;
      ok_q      <= 1'b0;
      out_key_q <= '0;
    end else begin
      done_q <= (state_q == ST_RESP);
      // mirror the root so peek and extract need no read
      if (cmd_o.we && (cmd_o.wlvl == '0)) begin
        min_q <= cmd_o.wdata;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (op_i == bmh_pkg::OP_INSERT) begin
              out_key_q <= '0;
              if (count_q == bmh_pkg::CNT_W'(bmh_pkg::CAPACITY)) begin
                ok_q    <= 1'b0;
                state_q <= ST_RESP;
              end else begin
                ok_q    <= 1'b1;
                cur_q   <= key_i;
                pos_q   <= count_q + bmh_pkg::IDX_W'(1);
                count_q <= count_q + bmh_pkg::CNT_W'(1);
                state_q <= ST_UP_CHK;
              end
            end else begin
              if (count_q == '0) begin
                ok_q      <= 1'b0;
                out_key_q <= '0;
                state_q   <= ST_RESP;
              end else begin
                ok_q      <= 1'b1;
                out_key_q <= min_q;
                count_q   <= count_q - bmh_pkg::CNT_W'(1);
                state_q   <= (count_q == bmh_pkg::CNT_W'(1)) ? ST_RESP : ST_DN_LAST;
              end
            end
          end
        end
        ST_UP_CHK: begin
          state_q <= (pos_q == bmh_pkg::IDX_W'(1)) ? ST_RESP : ST_UP_CMP;
        end
        ST_UP_CMP: begin
          if (up_swap) begin
            pos_q   <= par;
            state_q <= ST_UP_CHK;
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_DN_LAST: begin
          cur_q   <= rda_i;
          pos_q   <= bmh_pkg::IDX_W'(1);
          state_q <= ST_DN_CHK;
        end
        ST_DN_CHK: begin
          rc_ok_q <= rc_in;
          state_q <= lc_in ? ST_DN_CMP : ST_RESP;
        end
        ST_DN_CMP: begin
          if (take_l || take_r) begin
            pos_q   <= take_r ? rc_node[bmh_pkg::IDX_W-1:0] : lc_node[bmh_pkg::IDX_W-1:0];
            state_q <= ST_DN_CHK;
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o    = done_q;
  assign ok_o      = ok_q;
  assign out_key_o = out_key_q;
  assign count_o   = count_q;
  assign has_min_o = (count_q != '0);
  assign min_key_o = has_min_o ? min_q : '0;

  `BMH_ASSERT(a_done_idle, done_o |-> !busy, "result strobe while a transaction is active")
  `BMH_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction left no work")
  `BMH_ASSERT(a_count_cap, count_q <= bmh_pkg::CNT_W'(bmh_pkg::CAPACITY), "count over capacity")
  `BMH_ASSERT(a_up_pos, (state_q == ST_UP_CMP) |-> (pos_q > bmh_pkg::IDX_W'(1)), "root compare")
  `BMH_ASSERT(a_dn_child, (state_q == ST_DN_CMP) |-> $past(lc_in), "sift-down without a child")

endmodule

// ===== rtl/core/binary_min_heap.sv =====
`timescale 1ns / 1ps
// Binary min-heap priority queue of bmh_pkg::CAPACITY keys.
// Command channel: start with operation_i (insert or extract-min) and key_i
// is taken at a rising edge while busy is low. busy stays high until the
// transaction completes; one transaction is worked on at a time.
// Result channel: done_o is high for exactly one cycle with ok_o, out_key_o,
// count_o, has_min_o and min_key_o. The receiver must take it in that cycle.
// Datapath: each heap level is stored in its own cell memory; a sift step reads
// the neighbor level and compares and writes back in the next cycle.
// An insert moves its key up one level per sift step until it reaches the root
// or stops below its parent; an extract moves the last entry to the root and
// moves it down until it ends on a leaf or no child is smaller. Refused
// operations (insert into a full heap, extract from an empty heap) and an
// extract of the only entry go straight to the response state.
// done_o always coincides with busy low, so a new start may be accepted in
// that same cycle.
// Configuration: one APB register at address 0, bit 0 selects signed key
// ordering; write it only while busy is low. Reset empties the heap and
// selects unsigned ordering; the key memories are not cleared.

module binary_min_heap (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation_i,
  input  logic [bmh_pkg::KEY_W-1:0]      key_i,
  output logic                           done_o,
  output logic                           ok_o,
  output logic [bmh_pkg::KEY_W-1:0]      out_key_o,
  output logic [bmh_pkg::CNT_W-1:0]      count_o,
  output logic                           has_min_o,
  output logic [bmh_pkg::KEY_W-1:0]      min_key_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bmh_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic                       signed_keys_q;
  bmh_pkg::bmh_cmd_t          cmd;
  logic [bmh_pkg::KEY_W-1:0]  chain_a [bmh_pkg::NUM_LVL+1];
  logic [bmh_pkg::KEY_W-1:0]  chain_b [bmh_pkg::NUM_LVL+1];

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_keys_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == bmh_pkg::REG_SIGNED_KEYS)) begin
      signed_keys_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == bmh_pkg::REG_SIGNED_KEYS) ? {31'b0, signed_keys_q} : 32'b0;

  assign chain_a[bmh_pkg::NUM_LVL] = '0;
  assign chain_b[bmh_pkg::NUM_LVL] = '0;

  for (genvar l = 0; l < bmh_pkg::NUM_LVL; l++) begin : g_lvl
    localparam int LvlDepth = bmh_pkg::lvl_depth(l);
    localparam int LvlAw    = (LvlDepth > 1) ? $clog2(LvlDepth) : 1;

    bmh_pkg::bmh_req_t          req;
    logic [bmh_pkg::KEY_W-1:0]  rdata_a;
    logic [bmh_pkg::KEY_W-1:0]  rdata_b;

    bmh_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .lvl_i     (bmh_pkg::LVL_W'(l)),
      .cmd_i     (cmd),
      .req_o     (req),
      .rdataa_i  (rdata_a),
      .rdatab_i  (rdata_b),
      .chain_a_i (chain_a[l+1]),
      .chain_b_i (chain_b[l+1]),
      .chain_a_o (chain_a[l]),
      .chain_b_o (chain_b[l])
    );

    bmh_ram #(
      .DEPTH (LvlDepth),
      .AW    (LvlAw),
      .DW    (bmh_pkg::KEY_W)
    ) u_ram (
      .clk_i    (clk_i),
      .we_i     (req.we),
      .waddr_i  (req.waddr[LvlAw-1:0]),
      .wdata_i  (req.wdata),
      .rea_i    (req.rea),
      .raddra_i (req.raddra[LvlAw-1:0]),
      .rdataa_o (rdata_a),
      .reb_i    (req.reb),
      .raddrb_i (req.raddrb[LvlAw-1:0]),
      .rdatab_o (rdata_b)
    );
  end

  bmh_ctl u_ctl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (operation_i),
    .key_i         (key_i),
    .signed_keys_i (signed_keys_q),
    .cmd_o         (cmd),
    .rda_i         (chain_a[0]),
    .rdb_i         (chain_b[0]),
    .done_o        (done_o),
    .ok_o          (ok_o),
    .out_key_o     (out_key_o),
    .count_o       (count_o),
    .has_min_o     (has_min_o),
    .min_key_o     (min_key_o)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bmh_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
  } heap_req_t;

  typedef struct packed {
    logic             ok;
    logic [KEY_W-1:0] out_key;
    logic [CNT_W-1:0] count;
    logic             has_min;
    logic [KEY_W-1:0] min_key;
  } heap_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               operation_i = OP_INSERT;
  logic [KEY_W-1:0]   key_i       = '0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic               busy;
  logic               done_o;
  logic               ok_o;
  logic [KEY_W-1:0]   out_key_o;
  logic [CNT_W-1:0]   count_o;
  logic               has_min_o;
  logic [KEY_W-1:0]   min_key_o;
  logic [31:0]        prdata;
  logic               pready;

  binary_min_heap DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .key_i       (key_i),
    .done_o      (done_o),
    .ok_o        (ok_o),
    .out_key_o   (out_key_o),
    .count_o     (count_o),
    .has_min_o   (has_min_o),
    .min_key_o   (min_key_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow heap, updated as each transaction is accepted.
  logic [KEY_W-1:0] heap_keys [CAPACITY];
  int               shadow_count = 0;
  logic             order_signed = 1'b0;

  heap_req_t    pending_cmds [$];
  heap_result_t expected_results [$];

  int           planned_size = 0;
  logic [31:0]  last_key     = '0;
  int           burst_left   = 0;
  int           gap_left     = 0;
  int           errors       = 0;
  int           results_seen = 0;
  int           n_inserts    = 0;
  int           n_extracts   = 0;
  int           n_refused    = 0;
  int           n_writes     = 0;
  int           max_size     = 0;
  int           cycle_count  = 0;

  function automatic logic key_before(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    if (order_signed) begin
      return $signed(a) < $signed(b);
    end
    return a < b;
  endfunction

  function automatic heap_result_t apply_heap_op(heap_req_t req);
    heap_result_t     res;
    int               pos;
    int               parent;
    int               best;
    int               child;
    logic             moving;
    logic [KEY_W-1:0] tmp;
    res = '0;
    if (req.op == OP_INSERT) begin
      if (shadow_count < CAPACITY) begin
        pos = shadow_count;
        heap_keys[pos] = req.key;
        moving = 1'b1;
        while (moving && pos > 0) begin
          parent = (pos - 1) / 2;
          if (key_before(heap_keys[pos], heap_keys[parent])) begin
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[parent];
            heap_keys[parent] = tmp;
            pos = parent;
          end else begin
            moving = 1'b0;
          end
        end
        shadow_count++;
        res.ok = 1'b1;
      end
    end else if (shadow_count > 0) begin
      res.out_key = heap_keys[0];
      shadow_count--;
      res.ok = 1'b1;
      if (shadow_count > 0) begin
        heap_keys[0] = heap_keys[shadow_count];
        pos = 0;
        moving = 1'b1;
        while (moving) begin
          best = pos;
          child = 2 * pos + 1;
          if (child < shadow_count && key_before(heap_keys[child], heap_keys[best])) begin
            best = child;
          end
          child = 2 * pos + 2;
          if (child < shadow_count && key_before(heap_keys[child], heap_keys[best])) begin
            best = child;
          end
          if (best == pos) begin
            moving = 1'b0;
          end else begin
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[best];
            heap_keys[best] = tmp;
            pos = best;
          end
        end
      end
    end
    res.count   = CNT_W'(shadow_count);
    res.has_min = shadow_count > 0;
    res.min_key = (shadow_count > 0) ? heap_keys[0] : '0;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 19);
    case (r) inside
      0: pick_key = 32'h0000_0000;
      1: pick_key = 32'hFFFF_FFFF;
      2: pick_key = 32'h8000_0000;
      3: pick_key = 32'h7FFF_FFFF;
      [4:6]: pick_key = last_key;
      [7:9]: pick_key = $urandom_range(0, 15);
      [10:11]: pick_key = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: pick_key = $urandom;
    endcase
    last_key = pick_key;
  endfunction

  task automatic queue_op(input logic op, input logic [31:0] key);
    heap_req_t req;
    req.op  = op;
    req.key = key;
    pending_cmds.push_back(req);
    if (op == OP_INSERT && planned_size < CAPACITY) begin
      planned_size++;
    end else if (op == OP_EXTRACT && planned_size > 0) begin
      planned_size--;
    end
  endtask

  task automatic random_mix(input int n, input int insert_pct);
    for (int i = 0; i < n; i++) begin
      queue_op(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT, pick_key());
    end
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (pending_cmds.size() != 0 || expected_results.size() != 0 || start);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the key ordering register, then read it back.
  task automatic write_order(input logic value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(REG_SIGNED_KEYS) << 2;
    pwdata  <= {31'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    order_signed = value;
    n_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== value) begin
      $display("%0t: signed_keys readback expected %0d actual %0d", $time, value, prdata[0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: hold each command until accepted, then predict it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      operation_i <= OP_INSERT;
      key_i       <= '0;
      gap_left    = 0;
    end else begin
      if (start && !busy) begin
        heap_result_t res;
        res = apply_heap_op(pending_cmds.pop_front());
        expected_results.push_back(res);
        if (!res.ok) n_refused++;
        else if (operation_i == OP_INSERT) n_inserts++;
        else n_extracts++;
        if (shadow_count > max_size) max_size = shadow_count;
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
          gap_left = pick_gap();
        end
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          start       <= 1'b1;
          operation_i <= pending_cmds[0].op;
          key_i       <= pending_cmds[0].key;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result expected none actual ok=%0d out_key=%h count=%0d",
                 $time, ok_o, out_key_o, count_o);
        errors++;
      end else begin
        heap_result_t want;
        want = expected_results.pop_front();
        check_field("ok", want.ok, ok_o);
        check_field("out_key", want.out_key, out_key_o);
        check_field("count", want.count, count_o);
        check_field("has_min", want.has_min, has_min_o);
        check_field("min_key", want.min_key, min_key_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Unsigned order: empty extract, extreme and equal keys, drain past empty.
    queue_op(OP_EXTRACT, 32'hFFFF_FFFF);
    queue_op(OP_INSERT, 32'h0000_0000);
    queue_op(OP_INSERT, 32'hFFFF_FFFF);
    queue_op(OP_INSERT, 32'h8000_0000);
    queue_op(OP_INSERT, 32'h7FFF_FFFF);
    queue_op(OP_INSERT, 32'h7FFF_FFFF);
    queue_op(OP_INSERT, 32'h0000_0001);
    for (int i = 0; i < 7; i++) queue_op(OP_EXTRACT, 32'h0000_0000);
    wait_idle();

    // Same extremes in two's complement order; leave some held.
    write_order(1'b1);
    queue_op(OP_INSERT, 32'h7FFF_FFFF);
    queue_op(OP_INSERT, 32'h0000_0000);
    queue_op(OP_INSERT, 32'hFFFF_FFFF);
    queue_op(OP_INSERT, 32'h8000_0000);
    queue_op(OP_INSERT, 32'h8000_0000);
    queue_op(OP_INSERT, 32'h0000_0001);
    for (int i = 0; i < 4; i++) queue_op(OP_EXTRACT, 32'h5555_AAAA);
    random_mix(300, 60);
    wait_idle();

    // Flip the order with entries held, then fill to capacity and push past it.
    write_order(1'b0);
    while (planned_size < CAPACITY) queue_op(OP_INSERT, pick_key());
    for (int i = 0; i < 6; i++) queue_op(OP_INSERT, pick_key());
    random_mix(80, 50);
    wait_idle();

    write_order(1'b1);
    random_mix(250, 30);
    wait_idle();

    write_order(1'b0);
    random_mix(100, 45);
    wait_idle();

    $display("%0d results checked: %0d inserts, %0d extracts, %0d refused, peak size %0d",
             results_seen, n_inserts, n_extracts, n_refused, max_size);
    $display("%0d order register writes, both orderings, heap filled to capacity",
             n_writes);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
